### sv/fib_mod_period_pair_check_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fib_mod_period_pair_check_unit
// Clocked concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIB_MOD_PERIOD_PAIR_CHECK_UNIT_DEFINES_SVH
`define FIB_MOD_PERIOD_PAIR_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTH
// Property checked at every rising clock edge outside reset.
`define FMPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never hold at a rising clock edge outside reset.
`define FMPC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FMPC_ASSERT(label, prop, msg)
`define FMPC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

### sv/fmpc_pkg.sv
// ----------------------------------------------------------------------------
// fmpc_pkg
// Widths, constants and interface types shared by the period checker.
// ----------------------------------------------------------------------------
package fmpc_pkg;

  localparam int MOD_BITS   = 20;
  localparam int MULT_BITS  = 16;
  localparam int LEN_BITS   = 27;
  localparam int STEP_LIMIT = 100000000;

  // Dividend fed to the remainder unit: a product of two residues plus a residue.
  localparam int DIV_BITS = 2 * MOD_BITS + 1;
  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;

  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] divisor;
    logic [DIV_BITS-1:0] dividend;
  } fmpc_rem_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] rem;
  } fmpc_rem_rsp_t;

endpackage

### sv/fmpc_rem_unit.sv
// ----------------------------------------------------------------------------
// fmpc_rem_unit
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fmpc_rem_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fmpc_pkg::fmpc_rem_req_t req_i,
  output fmpc_pkg::fmpc_rem_rsp_t rsp_o
);
  import fmpc_pkg::*;

  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] div_q, div_d;
  logic [DIV_BITS-1:0] dvd_q, dvd_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [MOD_BITS:0]   trial;
  logic [MOD_BITS:0]   diff;

  // The partial remainder stays below the divisor, so the trial value is
  // below twice the divisor and one subtraction restores it.
  assign trial = {acc_q, dvd_q[DIV_BITS-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    acc_d  = acc_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d = '0;
      div_d = req_i.divisor;
      dvd_d = req_i.dividend;
      cnt_d = CNT_BITS'(DIV_BITS);
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = (trial >= {1'b0, div_q}) ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
      dvd_d = {dvd_q[DIV_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    div_q <= div_d;
    dvd_q <= dvd_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = acc_q;

endmodule

### sv/fib_mod_period_pair_check_unit.sv
// ----------------------------------------------------------------------------
// fib_mod_period_pair_check_unit
// Period of x[i] = (m*x[i-1] + x[i-2]) mod n and search for the pair (n-1, 0).
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result appears
// on pair_found_o, period_length_o and status_o for exactly one cycle, marked
// by done_o, and there is no way to hold it off, so the receiver must sample
// it in that cycle. A modulus of zero or one is answered in the cycle after
// the request and busy never rises. Any other modulus n runs the recurrence
// from the pair (1, m mod n) until that pair returns, one term at a time. All
// modular reduction goes through a single bit-serial remainder unit that
// handles one bit of a 41-bit dividend per cycle, and that unit sets the
// rate: each term goes through the multiply, the add, the remainder steps
// and the compare, and the initial m mod n also passes through the unit. A
// run that has not closed after 100000000 terms stops and reports status 2
// with that length. The multiplier register may only be written while busy
// is low.
module fib_mod_period_pair_check_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [fmpc_pkg::MOD_BITS-1:0] modulus_i,
  input  logic                          cfg_we_i,
  input  logic [fmpc_pkg::MULT_BITS-1:0] cfg_wdata_i,
  output logic                          done_o,
  output logic                          pair_found_o,
  output logic [fmpc_pkg::LEN_BITS-1:0] period_length_o,
  output logic [1:0]                    status_o
);
  import fmpc_pkg::*;

  `include "fib_mod_period_pair_check_unit_defines.svh"

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MM     = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_LAUNCH = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;

  // Last term index that may still be computed before the cap.
  localparam logic [LEN_BITS-1:0] IDX_LAST = LEN_BITS'(STEP_LIMIT - 1);
  localparam logic [LEN_BITS-1:0] LEN_CAP  = LEN_BITS'(STEP_LIMIT);

  logic [2:0]            state_q, state_d;
  logic [MULT_BITS-1:0]  mult_q;
  logic [MOD_BITS-1:0]   n_q, n_d;
  logic [MOD_BITS-1:0]   mm_q, mm_d;
  logic [MOD_BITS-1:0]   prev_q, prev_d;
  logic [MOD_BITS-1:0]   cur_q, cur_d;
  logic [LEN_BITS-1:0]   idx_q, idx_d;
  logic                  match_q, match_d;
  logic [2*MOD_BITS-1:0] prod_q, prod_d;
  logic                  done_q, done_d;
  logic                  found_q, found_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [1:0]            stat_q, stat_d;

  logic [MOD_BITS-1:0]   n_minus1;
  logic                  pair_hit;
  fmpc_rem_req_t         rem_req;
  fmpc_rem_rsp_t         rem_rsp;

  fmpc_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // The current pair (x[i-1], x[i]) equals the target (n-1, 0).
  assign n_minus1 = n_q - MOD_BITS'(1);
  assign pair_hit = (prev_q == n_minus1) && (cur_q == '0);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    mm_d    = mm_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    match_d = match_q;
    prod_d  = prod_q;
    done_d  = 1'b0;
    found_d = found_q;
    len_d   = len_q;
    stat_d  = stat_q;

    rem_req.start    = 1'b0;
    rem_req.divisor  = n_q;
    rem_req.dividend = {1'b0, prod_q} + {{(MOD_BITS+1){1'b0}}, prev_q};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (modulus_i == '0) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            len_d   = '0;
            stat_d  = ST_INVALID;
          end else if (modulus_i == MOD_BITS'(1)) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            len_d   = LEN_BITS'(1);
            stat_d  = ST_OK;
          end else begin
            // First job for the shared unit: reduce the multiplier mod n.
            n_d              = modulus_i;
            rem_req.start    = 1'b1;
            rem_req.divisor  = modulus_i;
            rem_req.dividend = {{(DIV_BITS-MULT_BITS){1'b0}}, mult_q};
            state_d          = S_MM;
          end
        end
      end
      S_MM: begin
        if (rem_rsp.done) begin
          mm_d    = rem_rsp.rem;
          prev_d  = MOD_BITS'(1);
          cur_d   = rem_rsp.rem;
          idx_d   = LEN_BITS'(1);
          match_d = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (idx_q < IDX_LAST) begin
          prod_d  = {{MOD_BITS{1'b0}}, mm_q} * {{MOD_BITS{1'b0}}, cur_q};
          state_d = S_LAUNCH;
        end else begin
          // Cap reached: the last pair still belongs to the checked range.
          done_d  = 1'b1;
          found_d = match_q | pair_hit;
          len_d   = LEN_CAP;
          stat_d  = ST_LIMIT;
          state_d = S_IDLE;
        end
      end
      S_LAUNCH: begin
        rem_req.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (rem_rsp.done) begin
          if ((rem_rsp.rem == mm_q) && (cur_q == MOD_BITS'(1))) begin
            // Starting pair is back; the period is the index of the old term.
            done_d  = 1'b1;
            found_d = match_q;
            len_d   = idx_q;
            stat_d  = ST_OK;
            state_d = S_IDLE;
          end else begin
            match_d = match_q | pair_hit;
            prev_d  = cur_q;
            cur_d   = rem_rsp.rem;
            idx_d   = idx_q + LEN_BITS'(1);
            state_d = S_MUL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mult_q  <= MULT_BITS'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        mult_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    mm_q    <= mm_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    idx_q   <= idx_d;
    match_q <= match_d;
    prod_q  <= prod_d;
    found_q <= found_d;
    len_q   <= len_d;
    stat_q  <= stat_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign pair_found_o    = found_q;
  assign period_length_o = len_q;
  assign status_o        = stat_q;

  // A result is only ever delivered once the sequencer is back at rest.
  `FMPC_ASSERT_NEVER(a_done_while_busy, done_o && busy, "result strobe while busy")
  // Any modulus of two or more starts a run on the next cycle.
  `FMPC_ASSERT(a_run_starts, (start && !busy && (modulus_i > MOD_BITS'(1))) |=> busy, "run did not start")
  // The shared unit never returns a residue at or above the modulus.
  `FMPC_ASSERT(a_rem_range, (busy && rem_rsp.done) |-> (rem_rsp.rem < n_q), "remainder out of range")
  // A closed period is never reported with zero length.
  `FMPC_ASSERT(a_ok_len, (done_o && (status_o == ST_OK)) |-> (period_length_o != '0), "zero period")

endmodule

### verif/period_result_checker.sv
// ----------------------------------------------------------------------------
// period_result_checker
// Watches the request, result and multiplier ports of the period unit. It
// predicts each result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module period_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [fmpc_pkg::MOD_BITS-1:0]  modulus_i,
  input  logic                           cfg_we_i,
  input  logic [fmpc_pkg::MULT_BITS-1:0] cfg_wdata_i,
  input  logic                           done_i,
  input  logic                           pair_found_i,
  input  logic [fmpc_pkg::LEN_BITS-1:0]  period_length_i,
  input  logic [1:0]                     status_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             found_o
);
  import fmpc_pkg::*;

  typedef struct packed {
    logic                pair_found;
    logic [LEN_BITS-1:0] period_length;
    logic [1:0]          status;
  } period_result_t;

  logic [MULT_BITS-1:0] multiplier_q;
  period_result_t       expected_periods[$];

  // Steps x[i] = (m*x[i-1] + x[i-2]) mod n from (1, m mod n) until that pair
  // comes back, watching for the pair (n-1, 0) on the way.
  function automatic period_result_t predict_period(input logic [MOD_BITS-1:0]  n,
                                                    input logic [MULT_BITS-1:0] m);
    period_result_t  r;
    longint unsigned nn, mm, prev_t, cur_t, next_t, idx;
    bit              closed;
    r.pair_found    = 1'b0;
    r.period_length = '0;
    r.status        = ST_OK;
    nn = n;
    if (nn == 0) begin
      r.status = ST_INVALID;
      return r;
    end
    if (nn == 1) begin
      r.period_length = LEN_BITS'(1);
      return r;
    end
    mm     = m % nn;
    prev_t = 1;
    cur_t  = mm;
    idx    = 1;
    closed = 1'b0;
    r.period_length = LEN_BITS'(STEP_LIMIT);
    r.status        = ST_LIMIT;
    while (!closed && idx + 1 < STEP_LIMIT) begin
      next_t = (mm * cur_t + prev_t) % nn;
      idx++;
      if (cur_t == 1 && next_t == mm) begin
        closed          = 1'b1;
        r.period_length = LEN_BITS'(idx - 1);
        r.status        = ST_OK;
      end else begin
        if (prev_t == nn - 1 && cur_t == 0) r.pair_found = 1'b1;
        prev_t = cur_t;
        cur_t  = next_t;
      end
    end
    // A capped run also checks the last pair it computed.
    if (!closed && prev_t == nn - 1 && cur_t == 0) r.pair_found = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    period_result_t want;
    if (!rst_ni) begin
      multiplier_q = MULT_BITS'(1);
      expected_periods.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      found_o      = 0;
    end else begin
      if (done_i) begin
        if (expected_periods.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_periods.pop_front();
          checked_o++;
          if (want.pair_found) found_o++;
          if (pair_found_i !== want.pair_found)
            report_mismatch($sformatf("pair_found %b, expected %b",
                                      pair_found_i, want.pair_found));
          if (period_length_i !== want.period_length)
            report_mismatch($sformatf("period_length %0d, expected %0d",
                                      period_length_i, want.period_length));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      status_i, want.status));
        end
      end
      // A request taken at this edge still sees the multiplier from before it.
      if (start_i && !busy_i)
        expected_periods.push_back(predict_period(modulus_i, multiplier_q));
      if (cfg_we_i) multiplier_q = cfg_wdata_i;
      pending_o = expected_periods.size();
    end
  end

endmodule

### verif/fib_mod_period_pair_check_unit_tb.sv
// ----------------------------------------------------------------------------
// fib_mod_period_pair_check_unit_tb
// Drives moduli and multiplier writes into the period unit and gives the
// verdict from the failure count of the checker that sits beside it.
// ----------------------------------------------------------------------------
// The run starts with a directed part: moduli zero and one, tiny moduli, the
// all-ones and top-bit-only moduli, a large Fibonacci modulus, and the
// multiplier at zero, one and its maximum. Random phases follow, each with a
// new multiplier written while the unit is idle. The step cap itself cannot
// be reached: every modulus sent here closes its period far below it.
module fib_mod_period_pair_check_unit_tb;
  import fmpc_pkg::*;

  // Worst item is a modulus up to 64 with a few hundred terms; the limit
  // covers the whole run several times over.
  localparam longint TIMEOUT_CYCLES = 64'd12_000_000;
  localparam int     PHASE_ITEMS    = 12;
  localparam int     RANDOM_PHASES  = 7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [MOD_BITS-1:0]  modulus_i;
  logic                 cfg_we_i;
  logic [MULT_BITS-1:0] cfg_wdata_i;
  logic                 done_o;
  logic                 pair_found_o;
  logic [LEN_BITS-1:0]  period_length_o;
  logic [1:0]           status_o;

  int fail_count;
  int periods_pending;
  int periods_checked;
  int pairs_found;

  // Stimulus bookkeeping.
  logic [MULT_BITS-1:0] mult_now;
  bit                   idle_en;
  int                   requests_sent;
  int                   mult_writes;

  fib_mod_period_pair_check_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .modulus_i      (modulus_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .pair_found_o   (pair_found_o),
    .period_length_o(period_length_o),
    .status_o       (status_o)
  );

  period_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .modulus_i      (modulus_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_i         (done_o),
    .pair_found_i   (pair_found_o),
    .period_length_i(period_length_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (periods_pending),
    .checked_o      (periods_checked),
    .found_o        (pairs_found)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Picks a modulus whose period stays short. With m = 0 the sequence is
  // 1, 0, 1, 0, ... for any modulus. Otherwise the modulus is a term G_k of
  // 0, 1, m, m*m+1, ...; modulo G_k the sequence scales by a unit whose square
  // is +-1 every k terms, so the period divides 4k even for 20-bit moduli.
  function automatic logic [MOD_BITS-1:0] pick_closing_modulus(
      input logic [MULT_BITS-1:0] m);
    longint unsigned g_prev, g_cur, g_next;
    longint unsigned terms[64];
    int              count;
    if (m == 0) return MOD_BITS'($urandom);
    g_prev = 1;
    g_cur  = m;
    count  = 0;
    while (g_cur < (64'd1 << MOD_BITS)) begin
      if (g_cur >= 2) begin
        terms[count] = g_cur;
        count++;
      end
      g_next = m * g_cur + g_prev;
      g_prev = g_cur;
      g_cur  = g_next;
    end
    // Favor the largest term so that the high modulus bits get exercised.
    if ($urandom_range(0, 1) == 1) return MOD_BITS'(terms[count-1]);
    return MOD_BITS'(terms[$urandom_range(0, count - 1)]);
  endfunction

  // Offers one request and returns at the edge where it is taken. Any idle
  // gap comes first, with junk on the modulus while start is low.
  task automatic send_modulus(input logic [MOD_BITS-1:0] n);
    int gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 99) < 30) begin
      gap   = $urandom_range(1, 40);
      start = 1'b0;
      repeat (gap) begin
        modulus_i = MOD_BITS'($urandom);
        @(negedge clk_i);
      end
    end
    start     = 1'b1;
    modulus_i = n;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
  endtask

  // Lowers start and holds off until every expected result has arrived.
  task automatic drain_requests();
    @(negedge clk_i);
    start = 1'b0;
    while (periods_pending != 0 || busy) @(negedge clk_i);
  endtask

  // The multiplier is only written with the unit idle.
  task automatic write_multiplier(input logic [MULT_BITS-1:0] m);
    drain_requests();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = m;
    mult_now    = m;
    mult_writes++;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = MULT_BITS'($urandom);
  endtask

  initial begin
    logic [MULT_BITS-1:0] phase_mult;
    logic [MOD_BITS-1:0]  n;
    int                   sel;
    rst_ni        = 1'b0;
    start         = 1'b0;
    modulus_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    mult_now      = MULT_BITS'(1);
    idle_en       = 1'b1;
    requests_sent = 0;
    mult_writes   = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, starting from the reset multiplier of one.
    send_modulus(MOD_BITS'(0));
    send_modulus(MOD_BITS'(1));
    send_modulus(MOD_BITS'(2));
    send_modulus(MOD_BITS'(3));      // Fibonacci mod 3 passes through (2, 0)
    send_modulus(MOD_BITS'(5));
    send_modulus(MOD_BITS'(832040)); // largest 20-bit Fibonacci number
    send_modulus(MOD_BITS'(7));
    send_modulus(MOD_BITS'(4));

    // Multiplier zero: period two for any modulus, so the widest moduli fit.
    write_multiplier(MULT_BITS'(0));
    send_modulus({MOD_BITS{1'b1}});
    send_modulus(MOD_BITS'(1) << (MOD_BITS - 1));
    send_modulus(MOD_BITS'(2));      // the starting pair (1, 0) is the target
    send_modulus(MOD_BITS'(0));

    // Maximum multiplier: it must be reduced before the first product.
    write_multiplier({MULT_BITS{1'b1}});
    send_modulus(MOD_BITS'(64));
    send_modulus(MOD_BITS'(65535));  // multiplier reduces to zero
    send_modulus(MOD_BITS'(61));
    send_modulus(MOD_BITS'(63));
    send_modulus(MOD_BITS'(1));

    // Random phases, each with its own multiplier. Phase two runs without
    // any idle gap, and phase four pauses until the unit has drained.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       phase_mult = MULT_BITS'(1);
        1:       phase_mult = MULT_BITS'(0);
        2:       phase_mult = MULT_BITS'(2);
        3:       phase_mult = MULT_BITS'($urandom_range(2, 65535));
        4:       phase_mult = {MULT_BITS{1'b1}};
        5:       phase_mult = MULT_BITS'($urandom_range(3, 20));
        default: phase_mult = MULT_BITS'(1);
      endcase
      write_multiplier(phase_mult);
      idle_en = (phase != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 4 && k == 7) drain_requests();
        sel = $urandom_range(0, 99);
        if (sel < 8)       n = MOD_BITS'($urandom_range(0, 1));
        else if (sel < 50) n = MOD_BITS'($urandom_range(2, 64));
        else               n = pick_closing_modulus(mult_now);
        send_modulus(n);
      end
    end

    // Let the last result come, then give the unit a little extra time so
    // that a stray result would still be caught.
    drain_requests();
    repeat (200) @(negedge clk_i);

    $display("Summary: %0d requests under %0d multiplier writes, %0d results checked,",
             requests_sent, mult_writes, periods_checked);
    $display("Summary: %0d of them with the pair (n-1, 0) inside the period.",
             pairs_found);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Timeout with %0d results still expected.", periods_pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/fmpc_pkg.sv
sv/fmpc_rem_unit.sv
sv/fib_mod_period_pair_check_unit.sv
verif/period_result_checker.sv
verif/fib_mod_period_pair_check_unit_tb.sv
